### rtl/string_literal_unescape_macros.svh
// Assertion macros for the string literal unescape block.
// Used by rtl/string_literal_unescape.sv; expects i_clk and i_rst_n in scope.
`ifndef STRING_LITERAL_UNESCAPE_MACROS_SVH
`define STRING_LITERAL_UNESCAPE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SLU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slu assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SLU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slu assertion failed");

`endif

### rtl/slu_pkg.sv
// Shared types, codes and helpers for the string literal unescape block.
// No dependencies; imported by every module under rtl/.
`default_nettype none

package slu_pkg;

    localparam int unsigned LINE_W   = 32;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_AT_NL  = 1'd1;

    localparam logic [7:0] DELIM_RESET = 8'd34;

    // status codes
    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_CLOSED  = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_UNTERM  = 2'd3;

    // characters
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BSLSH = 8'h5C;
    localparam logic [7:0] CH_LOW_B = 8'h62;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_LOW_N = 8'h6E;
    localparam logic [7:0] CH_LOW_R = 8'h72;
    localparam logic [7:0] CH_LOW_T = 8'h74;
    localparam logic [7:0] CH_LOW_V = 8'h76;

    typedef enum logic [4:0] {
        MODE_START  = 5'b00001,
        MODE_BODY   = 5'b00010,
        MODE_ESC    = 5'b00100,
        MODE_BLANK  = 5'b01000,
        MODE_BADESC = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [7:0] delimiter;
        logic       stop_at_newline;
    } t_cfg;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } t_beat_in;

    typedef struct packed {
        t_mode             mode;
        logic [LINE_W-1:0] line_count;
        logic [LINE_W-1:0] start_line;
    } t_scan;

    typedef struct packed {
        logic              char_valid;
        logic [7:0]        char_out;
        logic [1:0]        status;
        logic              consumed;
        logic [LINE_W-1:0] report_line;
    } t_result;

    function automatic logic is_blank(input logic [7:0] c);
        logic r;
        r = (c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR});
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/string_literal_unescape.sv
// String literal unescape top level: input register, decode step, result register.
// Pipeline: input register, then result register (2 reg stages).
// Throughput: 1 beat per cycle while the receiver takes results; the scan state updates
//   as a beat moves into the result register, so consecutive bytes decode back to back.
// Reset (i_rst_n low, synchronous): both stages empty, mode start of literal,
//   line and start line 1, delimiter 34, stop-at-newline off.
`default_nettype none
`include "string_literal_unescape_macros.svh"

module string_literal_unescape (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [slu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [slu_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    // source byte channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [7:0]                     i_byte_in,
    input  wire logic                           i_end_of_input,
    // decoded result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_char_valid,
    output logic [7:0]                          o_char_out,
    output logic [1:0]                          o_status,
    output logic                                o_consumed,
    output logic [slu_pkg::LINE_W-1:0]          o_report_line
);
    import slu_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    t_cfg w_cfg;

    slu_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // ---------------------------------------------------------------
    // Pipeline control
    // The input stage drains whenever the result stage is empty or its
    // beat is taken this cycle, so one beat moves per cycle under flow.
    // ---------------------------------------------------------------
    logic     r_in_valid;
    t_beat_in r_in;
    logic     r_out_valid;
    t_result  r_out;
    t_scan    r_scan;

    logic     w_out_free;
    logic     w_advance;
    logic     w_in_take;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;
    assign w_in_take  = i_in_valid && o_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.byte_in      <= i_byte_in;
            r_in.end_of_input <= i_end_of_input;
        end
    end

    // ---------------------------------------------------------------
    // Decode step: mode, line tracking, escape mapping
    // ---------------------------------------------------------------
    t_scan   n_scan;
    t_result n_res;

    slu_decode u_decode (
        .i_cfg  (w_cfg),
        .i_scan (r_scan),
        .i_beat (r_in),
        .o_scan (n_scan),
        .o_res  (n_res)
    );

    // scan state commits only when the beat enters the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.mode       <= MODE_START;
            r_scan.line_count <= LINE_W'(1);
            r_scan.start_line <= LINE_W'(1);
        end else if (w_advance) begin
            r_scan <= n_scan;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_char_valid  = r_out.char_valid;
    assign o_char_out    = r_out.char_out;
    assign o_status      = r_out.status;
    assign o_consumed    = r_out.consumed;
    assign o_report_line = r_out.report_line;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic w_final_beat;
    logic w_esc_beat;

    assign w_final_beat = w_advance && (n_res.status != ST_RUN);
    assign w_esc_beat   = w_advance && (r_scan.mode == MODE_ESC) && !r_in.end_of_input;

    // any final status restarts the literal scan
    `SLU_ASSERT_NEXT(a_final_restarts, w_final_beat, r_scan.mode == MODE_START)
    // an escape followed by a real byte is always consumed
    `SLU_ASSERT_NEXT(a_esc_consumed, w_esc_beat, r_out.consumed)
    // the line counter never goes backward
    `SLU_ASSERT_NEXT(a_line_monotonic, w_advance, r_scan.line_count >= $past(r_scan.line_count))
    // the literal cannot start after the current line
    `SLU_ASSERT_NOW(a_start_le_line, 1'b1, r_scan.start_line <= r_scan.line_count)

endmodule

`default_nettype wire

### rtl/slu_cfg.sv
// Configuration registers: delimiter and stop-at-newline.
// Depends on slu_pkg.
`default_nettype none

module slu_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [slu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [slu_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    output slu_pkg::t_cfg                       o_cfg
);
    import slu_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter       <= DELIM_RESET;
            r_cfg.stop_at_newline <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DELIMITER:  r_cfg.delimiter       <= i_cfg_data;
                CFG_STOP_AT_NL: r_cfg.stop_at_newline <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/slu_decode.sv
// Per-beat decode step: next scan state and the result for one source byte.
// Purely combinational; depends on slu_pkg.
`default_nettype none

module slu_decode (
    input  wire slu_pkg::t_cfg     i_cfg,
    input  wire slu_pkg::t_scan    i_scan,
    input  wire slu_pkg::t_beat_in i_beat,
    output slu_pkg::t_scan         o_scan,
    output slu_pkg::t_result       o_res
);
    import slu_pkg::*;

    logic [7:0]        c;
    logic              eof;
    logic [LINE_W-1:0] line_inc;
    logic              body;
    logic              valid;
    logic [7:0]        ch;
    logic [1:0]        status;
    logic              consumed;
    t_mode             n_mode;
    logic [LINE_W-1:0] n_line;
    logic [LINE_W-1:0] n_start;

    assign c   = i_beat.byte_in;
    assign eof = i_beat.end_of_input;

    // saturating line increment
    assign line_inc = (&i_scan.line_count) ? i_scan.line_count
                                           : i_scan.line_count + LINE_W'(1);

    always_comb begin
        body     = 1'b0;
        valid    = 1'b0;
        ch       = 8'h00;
        status   = ST_RUN;
        consumed = 1'b1;
        n_mode   = i_scan.mode;
        n_line   = i_scan.line_count;
        n_start  = i_scan.start_line;

        case (i_scan.mode)
            MODE_START: begin
                n_start = i_scan.line_count;
                body    = 1'b1;
            end
            MODE_BODY: begin
                body = 1'b1;
            end
            MODE_BLANK: begin
                body = eof || !is_blank(c);
            end
            MODE_ESC: begin
                if (eof) begin
                    status = ST_ILLEGAL;
                end else begin
                    n_mode = MODE_BODY;
                    valid  = 1'b1;
                    // escaped delimiter wins over the fixed letters
                    if (c == i_cfg.delimiter) ch = c;
                    else if (c == CH_SPACE)   ch = CH_SPACE;
                    else if (c == CH_LOW_B)   ch = CH_BS;
                    else if (c == CH_LOW_F)   ch = CH_FF;
                    else if (c == CH_LOW_N)   ch = CH_LF;
                    else if (c == CH_LOW_R)   ch = CH_CR;
                    else if (c == CH_LOW_T)   ch = CH_TAB;
                    else if (c == CH_LOW_V)   ch = CH_VT;
                    else if (c == CH_BSLSH)   ch = CH_BSLSH;
                    else if (c == CH_LF) begin
                        // line continuation
                        valid  = 1'b0;
                        n_line = line_inc;
                        n_mode = MODE_BLANK;
                    end else begin
                        valid  = 1'b0;
                        n_mode = MODE_BADESC;
                    end
                end
            end
            default: begin
                // bad escape: skip to delimiter or newline
                if (eof) begin
                    status = ST_ILLEGAL;
                end else if (c == CH_LF) begin
                    status   = ST_ILLEGAL;
                    consumed = 1'b0;
                end else if (c == i_cfg.delimiter) begin
                    status = ST_ILLEGAL;
                end else begin
                    n_mode = MODE_BADESC;
                end
            end
        endcase

        if (body) begin
            n_mode = MODE_BODY;
            if (eof) begin
                status = ST_UNTERM;
            end else if (c == i_cfg.delimiter) begin
                status = ST_CLOSED;
            end else if (c == CH_LF) begin
                if (i_cfg.stop_at_newline) begin
                    status   = ST_UNTERM;
                    consumed = 1'b0;
                end else begin
                    n_line = line_inc;
                    valid  = 1'b1;
                    ch     = c;
                    n_mode = MODE_BLANK;
                end
            end else if (c == CH_BSLSH) begin
                n_mode = MODE_ESC;
            end else begin
                valid = 1'b1;
                ch    = c;
            end
        end

        if (status != ST_RUN) begin
            n_mode = MODE_START;
        end

        o_scan.mode       = n_mode;
        o_scan.line_count = n_line;
        o_scan.start_line = n_start;

        o_res.char_valid  = valid;
        o_res.char_out    = valid ? ch : 8'h00;
        o_res.status      = status;
        o_res.consumed    = consumed;
        o_res.report_line = (status == ST_UNTERM) ? n_start : n_line;
    end

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for string_literal_unescape: byte beats in, decoded results out.
// Depends on rtl/slu_pkg.sv for codes and types; the expected results come from an
// in-bench decoder mirror kept inside a small scoreboard class.

module tb;
    import slu_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned PHASE_BEATS  = 120;
    localparam int unsigned N_PHASES     = 8;
    localparam int unsigned CALM_PHASE   = 5;   // no idling on either side
    localparam int unsigned STALL_PHASE  = 6;   // long receiver hold-off
    localparam int unsigned STALL_CYCLES = 150;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the decoder state and keeps the expected results
    // of all beats accepted but not yet seen on the output.
    // ------------------------------------------------------------------
    class lit_scoreboard;
        t_result     pending[$];
        logic [7:0]  delim;
        logic        stop_nl;
        t_mode       mode;
        logic [31:0] line_cnt;
        logic [31:0] start_ln;
        int          errors;
        int          n_beats;
        int          n_chars;
        int          st_seen[4];

        function new();
            delim    = DELIM_RESET;
            stop_nl  = 1'b0;
            mode     = MODE_START;
            line_cnt = 32'd1;
            start_ln = 32'd1;
            errors   = 0;
            n_beats  = 0;
            n_chars  = 0;
            foreach (st_seen[i]) st_seen[i] = 0;
        endfunction

        // register write; the scan mode is left alone
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            if (idx == CFG_DELIMITER)
                delim = data;
            else if (idx == CFG_STOP_AT_NL)
                stop_nl = data[0];
        endfunction

        function void bump_line();
            if (line_cnt != '1)
                line_cnt = line_cnt + 32'd1;
        endfunction

        // one decode step of the literal scanner
        function t_result decode_byte(logic [7:0] c, logic eof);
            t_result r;
            logic    body;
            logic [1:0] st;
            r.char_valid = 1'b0;
            r.char_out   = 8'h00;
            r.consumed   = 1'b1;
            st           = ST_RUN;
            body         = 1'b0;
            case (mode)
                MODE_START: begin
                    start_ln = line_cnt;
                    body     = 1'b1;
                end
                MODE_BODY: body = 1'b1;
                MODE_BLANK: begin
                    // blanks after a newline are dropped, even when a blank is the delimiter
                    if (eof || !(c == CH_SPACE || c == CH_TAB || c == CH_VT ||
                                 c == CH_FF || c == CH_CR))
                        body = 1'b1;
                end
                MODE_ESC: begin
                    if (eof) begin
                        st = ST_ILLEGAL;
                    end else begin
                        mode         = MODE_BODY;
                        r.char_valid = 1'b1;
                        if (c == delim) begin
                            r.char_out = c;
                        end else begin
                            case (c)
                                CH_SPACE: r.char_out = CH_SPACE;
                                CH_LOW_B: r.char_out = CH_BS;
                                CH_LOW_F: r.char_out = CH_FF;
                                CH_LOW_N: r.char_out = CH_LF;
                                CH_LOW_R: r.char_out = CH_CR;
                                CH_LOW_T: r.char_out = CH_TAB;
                                CH_LOW_V: r.char_out = CH_VT;
                                CH_BSLSH: r.char_out = CH_BSLSH;
                                CH_LF: begin
                                    r.char_valid = 1'b0;
                                    bump_line();
                                    mode = MODE_BLANK;
                                end
                                default: begin
                                    r.char_valid = 1'b0;
                                    mode = MODE_BADESC;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    // skipping a bad escape up to delimiter or newline
                    if (eof) begin
                        st = ST_ILLEGAL;
                    end else if (c == CH_LF) begin
                        st         = ST_ILLEGAL;
                        r.consumed = 1'b0;
                    end else if (c == delim) begin
                        st = ST_ILLEGAL;
                    end else begin
                        mode = MODE_BADESC;
                    end
                end
            endcase

            if (body) begin
                mode = MODE_BODY;
                if (eof) begin
                    st = ST_UNTERM;
                end else if (c == delim) begin
                    st = ST_CLOSED;
                end else if (c == CH_LF) begin
                    if (stop_nl) begin
                        st         = ST_UNTERM;
                        r.consumed = 1'b0;
                    end else begin
                        bump_line();
                        r.char_valid = 1'b1;
                        r.char_out   = c;
                        mode         = MODE_BLANK;
                    end
                end else if (c == CH_BSLSH) begin
                    mode = MODE_ESC;
                end else begin
                    r.char_valid = 1'b1;
                    r.char_out   = c;
                end
            end

            if (st != ST_RUN)
                mode = MODE_START;
            r.status      = st;
            r.report_line = (st == ST_UNTERM) ? start_ln : line_cnt;
            return r;
        endfunction

        function void note_beat(t_beat_in bt);
            pending.push_back(decode_byte(bt.byte_in, bt.end_of_input));
            n_beats++;
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            cmp_field("char_valid", 32'(want.char_valid), 32'(got.char_valid));
            cmp_field("char_out", 32'(want.char_out), 32'(got.char_out));
            cmp_field("status", 32'(want.status), 32'(got.status));
            cmp_field("consumed", 32'(want.consumed), 32'(got.consumed));
            cmp_field("report_line", want.report_line, got.report_line);
            st_seen[want.status]++;
            if (want.char_valid)
                n_chars++;
        endfunction

        function int pending_count();
            return pending.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [7:0]           i_byte_in;
    logic                 i_end_of_input;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_char_valid;
    logic [7:0]           o_char_out;
    logic [1:0]           o_status;
    logic                 o_consumed;
    logic [LINE_W-1:0]    o_report_line;

    string_literal_unescape dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_byte_in      (i_byte_in),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_char_valid   (o_char_valid),
        .o_char_out     (o_char_out),
        .o_status       (o_status),
        .o_consumed     (o_consumed),
        .o_report_line  (o_report_line)
    );

    lit_scoreboard sb = new();
    t_beat_in      beat_q[$];       // source bytes waiting to be driven
    logic [7:0]    cur_delim = DELIM_RESET;
    bit            no_idle = 1'b0;  // set for the calm phase: both sides always ready
    bit            stall_request = 1'b0;
    int unsigned   cycle_cnt = 0;
    int unsigned   n_settings = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run-away guard
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d results still expected",
                 cycle_cnt, sb.pending_count());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure, plus one long hold-off on request.
    // The hold-off is counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                hold_left     = STALL_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (no_idle) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= 19);
            end
        end
    end

    // sample pre-edge values: a beat moves when valid and ready were both high
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.char_valid  = o_char_valid;
            got.char_out    = o_char_out;
            got.status      = o_status;
            got.consumed    = o_consumed;
            got.report_line = o_report_line;
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------
    // Source byte generation
    // ------------------------------------------------------------------
    function automatic void push_byte(logic [7:0] b);
        t_beat_in bt;
        bt.byte_in      = b;
        bt.end_of_input = 1'b0;
        beat_q.push_back(bt);
    endfunction

    // byte field is don't-care on end of input, so keep it random
    function automatic void push_eof();
        t_beat_in bt;
        bt.byte_in      = 8'($urandom_range(0, 255));
        bt.end_of_input = 1'b1;
        beat_q.push_back(bt);
    endfunction

    function automatic logic [7:0] blank_pick();
        case ($urandom_range(0, 4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_VT;
            3:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic void push_blanks();
        repeat ($urandom_range(0, 3)) push_byte(blank_pick());
    endfunction

    // character after a backslash; last two choices are mostly illegal
    function automatic logic [7:0] escape_pick();
        case ($urandom_range(0, 10))
            0:       return cur_delim;
            1:       return CH_SPACE;
            2:       return CH_LOW_B;
            3:       return CH_LOW_F;
            4:       return CH_LOW_N;
            5:       return CH_LOW_R;
            6:       return CH_LOW_T;
            7:       return CH_LOW_V;
            8:       return CH_BSLSH;
            9:       return 8'($urandom_range(8'h21, 8'h7E));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one literal body with random content, usually closed properly
    function automatic void gen_literal();
        int unsigned pick;
        int unsigned n;
        n = $urandom_range(0, 10);
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                push_byte(8'($urandom_range(8'h21, 8'h7E)));
            end else if (pick < 55) begin
                push_byte(blank_pick());
            end else if (pick < 72) begin
                push_byte(CH_BSLSH);
                push_byte(escape_pick());
            end else if (pick < 80) begin
                push_byte(CH_LF);
                push_blanks();
            end else if (pick < 88) begin
                push_byte(8'($urandom_range(0, 255)));
            end else begin
                // line continuation
                push_byte(CH_BSLSH);
                push_byte(CH_LF);
                push_blanks();
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 78)
            push_byte(cur_delim);
        else if (pick < 88)
            push_eof();
        else if (pick >= 94)
            push_byte(CH_LF);
        // else: left open, next literal runs on
    endfunction

    function automatic void gen_noise();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 9) == 0)
                push_eof();
            else
                push_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void gen_random(int unsigned n);
        while (beat_q.size() < n) begin
            if ($urandom_range(0, 9) == 0)
                gen_noise();
            else
                gen_literal();
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_beat(t_beat_in bt);
        while (!no_idle && $urandom_range(0, 99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_byte_in      <= bt.byte_in;
        i_end_of_input <= bt.end_of_input;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_beat(bt);
    endtask

    // drive the whole queue, then wait for every result and let the pipe empty
    task automatic run_beats();
        while (beat_q.size() != 0)
            send_beat(beat_q.pop_front());
        i_in_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // both registers, back to back; only called with the block idle
    task automatic set_config(logic [7:0] delim, logic stop_nl);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DELIMITER;
        i_cfg_data  <= delim;
        @(posedge i_clk);
        sb.set_reg(CFG_DELIMITER, delim);
        i_cfg_index <= CFG_STOP_AT_NL;
        i_cfg_data  <= {{(CFG_DAT_W-1){1'b0}}, stop_nl};
        @(posedge i_clk);
        sb.set_reg(CFG_STOP_AT_NL, {{(CFG_DAT_W-1){1'b0}}, stop_nl});
        i_cfg_we  <= 1'b0;
        cur_delim  = delim;
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] ph_delim [N_PHASES];
        logic       ph_stop  [N_PHASES];

        // extremes, blank-as-delimiter, newline and backslash as delimiter
        ph_delim = '{8'hFF, 8'h00, CH_SPACE, CH_LF, CH_BSLSH, 8'h27, 8'h00, DELIM_RESET};
        ph_stop  = '{1'b1,  1'b0,  1'b0,     1'b1,  1'b0,     1'b1,  1'b0, 1'b0};
        ph_delim[STALL_PHASE] = 8'($urandom_range(0, 255));
        ph_stop[STALL_PHASE]  = 1'($urandom_range(0, 1));

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= CFG_DELIMITER;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_byte_in      <= 8'h00;
        i_end_of_input <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings (delimiter is the double quote).
        // every escape letter, escaped delimiter first
        push_byte(CH_BSLSH); push_byte(DELIM_RESET);
        push_byte(CH_BSLSH); push_byte(CH_LOW_B);
        push_byte(CH_BSLSH); push_byte(CH_LOW_F);
        push_byte(CH_BSLSH); push_byte(CH_LOW_N);
        push_byte(CH_BSLSH); push_byte(CH_LOW_R);
        push_byte(CH_BSLSH); push_byte(CH_LOW_T);
        push_byte(CH_BSLSH); push_byte(CH_LOW_V);
        push_byte(CH_BSLSH); push_byte(CH_SPACE);
        push_byte(CH_BSLSH); push_byte(CH_BSLSH);
        // continuation: blank skipped, next byte decoded as usual
        push_byte(CH_BSLSH); push_byte(CH_LF); push_byte(CH_TAB); push_byte(8'h78);
        push_byte(DELIM_RESET);
        // illegal escape ended by a newline: the newline comes back unconsumed,
        // so present it again as the first byte of a new literal
        push_byte(CH_BSLSH); push_byte(8'h71); push_byte(CH_LF);
        push_byte(CH_LF);
        push_eof();
        // a bit of random content at reset settings too
        gen_random(PHASE_BEATS);
        run_beats();

        for (int p = 0; p < N_PHASES; p++) begin
            set_config(ph_delim[p], ph_stop[p]);
            no_idle = (p == CALM_PHASE);
            gen_random(PHASE_BEATS);
            if (p == STALL_PHASE)
                stall_request = 1'b1;
            run_beats();
        end
        no_idle = 1'b0;
        repeat (8) @(posedge i_clk);

        $display("Ran %0d source beats through %0d register settings plus defaults,",
                 sb.n_beats, n_settings);
        $display("with a %0d-cycle output hold-off. Seen: %0d chars, %0d closed,",
                 STALL_CYCLES, sb.n_chars, sb.st_seen[ST_CLOSED]);
        $display("%0d bad escapes, %0d unterminated literals.",
                 sb.st_seen[ST_ILLEGAL], sb.st_seen[ST_UNTERM]);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
